[sv/hmdt_pkg.sv]
`timescale 1ns / 1ps

package hmdt_pkg;

  // table geometry
  localparam int LEVEL_BITS    = 8;
  localparam int ROOT_SIZE     = 1 << LEVEL_BITS;
  localparam int MAX_CODE_BITS = 16;
  localparam int SUBTABLE_POOL = 16;

  // field widths
  localparam int SYM_W  = 10;
  localparam int LEN_W  = 5;
  localparam int CODE_W = 16;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_MATCH  = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  // one table entry, length zero means empty
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [SYM_W-1:0] sym;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[sv/huffman_multilevel_decode_table.sv]
`timescale 1ns / 1ps
// Decode: a root hit passes through DEC1 and DONE from acceptance to the result;
// a subtable hit also passes DEC2 (two dependent reads of the entry memory).
// Insert: FILL writes one entry per cycle (up to 128) for a short code, and a long
// code first reads its root link in LINK; the single write port sets this.
// One transaction in flight; reset starts a clearing pass over the entry memory
// ((SUBTABLE_POOL+1)*256 entries) and link memory; no input is taken meanwhile.
module huffman_multilevel_decode_table #(
  parameter int SUBTABLE_POOL = hmdt_pkg::SUBTABLE_POOL
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic [hmdt_pkg::CODE_W-1:0]         code_value,
  input  logic [hmdt_pkg::LEN_W-1:0]          code_length,
  input  logic signed [hmdt_pkg::SYM_W:0]     code_symbol,
  input  logic [hmdt_pkg::CODE_W-1:0]         stream_bits,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hmdt_pkg::SYM_W-1:0]          symbol_out,
  output logic [hmdt_pkg::LEN_W-1:0]          length_out,
  output logic [1:0]                          status
);

  import hmdt_pkg::*;

  // row 0 of the entry memory is the root table, rows 1.. are subtables
  localparam int ROWS      = SUBTABLE_POOL + 1;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int ENT_DEPTH = ROWS * ROOT_SIZE;
  localparam int ENT_AW    = ROW_W + LEVEL_BITS;
  localparam int SUB_W     = (SUBTABLE_POOL > 1) ? $clog2(SUBTABLE_POOL) : 1;
  localparam int USED_W    = $clog2(SUBTABLE_POOL + 1);
  localparam int LINK_W    = SUB_W + 1;
  localparam int FCNT_W    = LEVEL_BITS - 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC1  = 3'd2;
  localparam logic [2:0] S_DEC2  = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]            state;
  logic [ENT_AW-1:0]     clr_addr;
  logic [USED_W-1:0]     used;
  logic [LEVEL_BITS-1:0] op_hi;
  logic [LEVEL_BITS-1:0] link_addr;
  logic [LEN_W-1:0]      op_len;
  entry_t                op_entry;
  logic [LEVEL_BITS-1:0] fill_bits;
  logic [3:0]            fill_active;
  logic [ROW_W-1:0]      fill_row;
  logic [FCNT_W-1:0]     fill_cnt;
  logic [SYM_W-1:0]      res_sym;
  logic [LEN_W-1:0]      res_len;
  logic [1:0]            res_status;

  logic                  ent_we;
  logic [ENT_AW-1:0]     ent_waddr;
  entry_t                ent_wdata;
  logic [ENT_AW-1:0]     ent_raddr;
  entry_t                ent_rdata;
  logic                  link_we;
  logic [LEVEL_BITS-1:0] link_waddr;
  logic [LINK_W-1:0]     link_wdata;
  logic [LEVEL_BITS-1:0] link_raddr;
  logic [LINK_W-1:0]     link_rdata;

  logic                  accept;
  logic                  out_free;
  logic [CODE_W:0]       code_mask;
  logic [CODE_W-1:0]     code_bits;
  logic                  sym_unused;
  logic [ROW_W-1:0]      link_row;
  logic [LEVEL_BITS-1:0] fill_idx;
  logic                  fill_last;
  logic                  clr_root;
  logic                  can_alloc;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // insert operand decode
  assign code_mask  = (CODE_W+1)'(((CODE_W+1)'(1) << code_length) - (CODE_W+1)'(1));
  assign code_bits  = code_value & code_mask[CODE_W-1:0];
  assign sym_unused = (code_symbol == -11'sd1);

  // subtable row from the link read out of the link memory
  assign link_row  = ROW_W'(link_rdata[SUB_W-1:0]) + ROW_W'(1);
  assign can_alloc = (used < USED_W'(SUBTABLE_POOL));

  // fill walks every entry whose low bits equal the code
  assign fill_idx  = LEVEL_BITS'({1'b0, fill_cnt} << fill_active) | fill_bits;
  assign fill_last = (fill_cnt == FCNT_W'(8'hff >> fill_active));
  assign clr_root  = (clr_addr[ENT_AW-1:LEVEL_BITS] == '0);

  // entry memory port control
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = clr_addr;
    ent_wdata = '0;
    if (state == S_CLEAR) begin
      ent_we = 1'b1;
    end else if (state == S_FILL) begin
      ent_we    = 1'b1;
      ent_waddr = {fill_row, fill_idx};
      ent_wdata = op_entry;
    end
    if (state == S_DEC1) begin
      ent_raddr = {link_row, op_hi};
    end else begin
      ent_raddr = {ROW_W'(0), stream_bits[LEVEL_BITS-1:0]};
    end
  end

  // link memory port control
  always_comb begin
    link_we    = 1'b0;
    link_waddr = clr_addr[LEVEL_BITS-1:0];
    link_wdata = '0;
    if (state == S_CLEAR) begin
      link_we = clr_root;
    end else if (state == S_LINK && !link_rdata[SUB_W] && can_alloc) begin
      link_we    = 1'b1;
      link_waddr = link_addr;
      link_wdata = {1'b1, used[SUB_W-1:0]};
    end
    link_raddr = (command == CMD_DECODE) ? stream_bits[LEVEL_BITS-1:0]
                                         : code_value[LEVEL_BITS-1:0];
  end

  hmdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENT_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  hmdt_ram #(
    .WIDTH (LINK_W),
    .DEPTH (ROOT_SIZE)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      // result handshake
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ENT_AW'(1);
          if (clr_addr == ENT_AW'(ENT_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (command == CMD_DECODE) begin
              state <= S_DEC1;
            end else if (sym_unused || code_length == '0) begin
              state <= S_DONE;
            end else if (code_length > LEN_W'(MAX_CODE_BITS)) begin
              state <= S_DONE;
            end else if (code_length <= LEN_W'(LEVEL_BITS)) begin
              state <= S_FILL;
            end else begin
              state <= S_LINK;
            end
          end
        end
        S_DEC1: begin
          if (ent_rdata.len == '0 && link_rdata[SUB_W]) begin
            state <= S_DEC2;
          end else begin
            state <= S_DONE;
          end
        end
        S_DEC2: begin
          state <= S_DONE;
        end
        S_LINK: begin
          if (link_rdata[SUB_W]) begin
            state <= S_FILL;
          end else if (can_alloc) begin
            used  <= used + USED_W'(1);
            state <= S_FILL;
          end else begin
            state <= S_DONE;
          end
        end
        S_FILL: begin
          if (fill_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // operand, fill and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_len      <= code_length;
          op_entry    <= '{len: code_length, sym: code_symbol[SYM_W-1:0]};
          link_addr   <= code_bits[LEVEL_BITS-1:0];
          fill_cnt    <= '0;
          fill_row    <= '0;
          fill_bits   <= code_bits[LEVEL_BITS-1:0];
          fill_active <= code_length[3:0];
          res_sym     <= '0;
          res_len     <= '0;
          res_status  <= ST_OK;
          if (command == CMD_DECODE) begin
            op_hi <= stream_bits[2*LEVEL_BITS-1:LEVEL_BITS];
          end else begin
            op_hi <= code_bits[2*LEVEL_BITS-1:LEVEL_BITS];
            if (!sym_unused && code_length != '0 &&
                code_length > LEN_W'(MAX_CODE_BITS)) begin
              res_status <= ST_TOO_LONG;
            end
          end
        end
      end
      S_DEC1: begin
        if (ent_rdata.len != '0) begin
          res_sym <= ent_rdata.sym;
          res_len <= ent_rdata.len;
        end else if (!link_rdata[SUB_W]) begin
          res_status <= ST_NO_MATCH;
        end
      end
      S_DEC2: begin
        if (ent_rdata.len != '0) begin
          res_sym <= ent_rdata.sym;
          res_len <= ent_rdata.len;
        end else begin
          res_status <= ST_NO_MATCH;
        end
      end
      S_LINK: begin
        fill_bits   <= op_hi;
        fill_active <= 4'(op_len - LEN_W'(LEVEL_BITS));
        if (link_rdata[SUB_W]) begin
          fill_row <= link_row;
        end else if (can_alloc) begin
          fill_row <= ROW_W'(used) + ROW_W'(1);
        end else begin
          res_status <= ST_POOL_FULL;
        end
      end
      S_FILL: begin
        fill_cnt <= fill_cnt + FCNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      symbol_out <= res_sym;
      length_out <= res_len;
      status     <= res_status;
    end
  end

  // pool counter never runs past the pool
  assert property (@(posedge clk) disable iff (rst) used <= USED_W'(SUBTABLE_POOL))
    else $error("subtable count beyond pool");

  // each new link takes exactly one subtable
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK && link_we) |=> used == $past(used) + USED_W'(1))
    else $error("link written without allocation");

  // fill walk stays inside its entry set
  assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |-> fill_cnt <= FCNT_W'(8'hff >> fill_active))
    else $error("fill counter overran");

  // a nonzero result symbol always carries a code length
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free && res_sym != '0) |-> res_len != '0)
    else $error("symbol without length");

endmodule

[sv/hmdt_ram.sv]
`timescale 1ns / 1ps

module hmdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/sv/decode_table_checker.sv]
`timescale 1ns / 1ps

module decode_table_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               command,
  input  logic [hmdt_pkg::CODE_W-1:0]        code_value,
  input  logic [hmdt_pkg::LEN_W-1:0]         code_length,
  input  logic signed [hmdt_pkg::SYM_W:0]    code_symbol,
  input  logic [hmdt_pkg::CODE_W-1:0]        stream_bits,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [hmdt_pkg::SYM_W-1:0]         symbol_out,
  input  logic [hmdt_pkg::LEN_W-1:0]         length_out,
  input  logic [1:0]                         status,
  output int                                 failures,
  output int                                 pending
);

  import hmdt_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
    logic [1:0]       st;
  } answer_t;

  // shadow copy of the decode tables
  entry_t     root_tab    [ROOT_SIZE];
  logic       root_linked [ROOT_SIZE];
  logic [7:0] root_sub    [ROOT_SIZE];
  entry_t     sub_tab     [SUBTABLE_POOL*ROOT_SIZE];
  int         subs_taken;

  answer_t answers_due[$];
  int      mismatch_count = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void clear_tables();
    for (int i = 0; i < ROOT_SIZE; i++) begin
      root_tab[i]    = '0;
      root_linked[i] = 1'b0;
      root_sub[i]    = '0;
    end
    for (int i = 0; i < SUBTABLE_POOL*ROOT_SIZE; i++) sub_tab[i] = '0;
    subs_taken = 0;
  endfunction

  // write every entry of one level whose low bits match the code
  function automatic void fill_level(input bit in_sub, input int base, input int bits,
                                     input int active, input entry_t e);
    int idx;
    for (int i = 0; i < (1 << (LEVEL_BITS - active)); i++) begin
      idx = ((i << active) | bits) & (ROOT_SIZE - 1);
      if (in_sub) sub_tab[base + idx] = e;
      else root_tab[idx] = e;
    end
  endfunction

  // apply one transaction to the shadow tables and return its answer
  function automatic answer_t predict_answer(input logic cmd, input logic [CODE_W-1:0] val,
                                             input logic [LEN_W-1:0] len,
                                             input logic signed [SYM_W:0] sym,
                                             input logic [CODE_W-1:0] bits_in);
    answer_t a;
    entry_t  e;
    int      bits;
    int      ridx;
    int      sub;
    a = '0;
    a.st = ST_OK;
    if (cmd == CMD_INSERT) begin
      if (sym == -1 || len == 0) return a;
      if (len > MAX_CODE_BITS) begin
        a.st = ST_TOO_LONG;
        return a;
      end
      bits = int'(val) & ((1 << len) - 1);
      e.len = len;
      e.sym = sym[SYM_W-1:0];
      if (len <= LEVEL_BITS) begin
        fill_level(1'b0, 0, bits, int'(len), e);
      end else begin
        ridx = bits & (ROOT_SIZE - 1);
        if (root_linked[ridx]) begin
          sub = int'(root_sub[ridx]);
        end else if (subs_taken < SUBTABLE_POOL) begin
          sub = subs_taken;
          root_linked[ridx] = 1'b1;
          root_sub[ridx] = sub[7:0];
          subs_taken++;
        end else begin
          a.st = ST_POOL_FULL;
          return a;
        end
        fill_level(1'b1, sub * ROOT_SIZE, bits >> LEVEL_BITS, int'(len) - LEVEL_BITS, e);
      end
      return a;
    end
    // decode: root first, then the linked subtable
    ridx = int'(bits_in[LEVEL_BITS-1:0]);
    e = root_tab[ridx];
    if (e.len != 0) begin
      a.sym = e.sym;
      a.len = e.len;
      return a;
    end
    if (root_linked[ridx]) begin
      e = sub_tab[int'(root_sub[ridx]) * ROOT_SIZE + int'(bits_in[CODE_W-1:LEVEL_BITS])];
      if (e.len != 0) begin
        a.sym = e.sym;
        a.len = e.len;
        return a;
      end
    end
    a.st = ST_NO_MATCH;
    return a;
  endfunction

  // compare results, then predict newly accepted transactions
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      clear_tables();
      answers_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result symbol %0d length %0d status %0d",
                                    symbol_out, length_out, status));
        end else begin
          want = answers_due.pop_front();
          if (symbol_out !== want.sym)
            report_mismatch($sformatf("symbol_out got %0d want %0d", symbol_out, want.sym));
          if (length_out !== want.len)
            report_mismatch($sformatf("length_out got %0d want %0d", length_out, want.len));
          if (status !== want.st)
            report_mismatch($sformatf("status got %0d want %0d", status, want.st));
        end
      end
      if (in_valid && !in_stall)
        answers_due.push_back(predict_answer(command, code_value, code_length,
                                             code_symbol, stream_bits));
    end
    pending  <= answers_due.size();
    failures <= mismatch_count;
  end

endmodule

[tb/sv/huffman_multilevel_decode_table_test.sv]
`timescale 1ns / 1ps

module huffman_multilevel_decode_table_test;
  import hmdt_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int CODE_MEMORY  = 64;

  typedef struct {
    logic [CODE_W-1:0] val;
    int                len;
  } codeword_t;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  command     = CMD_INSERT;
  logic [CODE_W-1:0]     code_value  = '0;
  logic [LEN_W-1:0]      code_length = '0;
  logic signed [SYM_W:0] code_symbol = '0;
  logic [CODE_W-1:0]     stream_bits = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [SYM_W-1:0]      symbol_out;
  logic [LEN_W-1:0]      length_out;
  logic [1:0]            status;
  int                    failures;
  int                    pending;

  int idle_pct  = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int idle_pct_tab  [4] = '{0, 77, 0, 9};
  int stall_pct_tab [4] = '{0, 0, 77, 9};
  codeword_t known_codes[$];

  huffman_multilevel_decode_table i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .code_value  (code_value),
    .code_length (code_length),
    .code_symbol (code_symbol),
    .stream_bits (stream_bits),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol_out  (symbol_out),
    .length_out  (length_out),
    .status      (status)
  );

  decode_table_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .code_value  (code_value),
    .code_length (code_length),
    .code_symbol (code_symbol),
    .stream_bits (stream_bits),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol_out  (symbol_out),
    .length_out  (length_out),
    .status      (status),
    .failures    (failures),
    .pending     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // present one transaction after a random gap and wait for acceptance
  task automatic send_item(input logic cmd, input logic [CODE_W-1:0] val,
                           input logic [LEN_W-1:0] len, input logic signed [SYM_W:0] sym,
                           input logic [CODE_W-1:0] bits);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    code_value  <= val;
    code_length <= len;
    code_symbol <= sym;
    stream_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic put_code(input logic [CODE_W-1:0] val, input logic [LEN_W-1:0] len,
                          input logic signed [SYM_W:0] sym);
    send_item(CMD_INSERT, val, len, sym, CODE_W'($urandom));
  endtask

  task automatic query(input logic [CODE_W-1:0] bits);
    send_item(CMD_DECODE, CODE_W'($urandom), LEN_W'($urandom), (SYM_W+1)'($urandom), bits);
  endtask

  // mostly inserts of random codewords and decodes of those codewords, some noise
  task automatic random_transaction();
    int                    pick;
    int                    k;
    int                    len;
    int                    sym;
    logic [CODE_W-1:0]     val;
    logic [31:0]           wide;
    codeword_t             cw;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      val = CODE_W'($urandom);
      sym = $urandom_range(0, 1023);
      k = $urandom_range(0, 99);
      if (k < 2) len = $urandom_range(1, 2);
      else if (k < 30) len = $urandom_range(3, 8);
      else len = $urandom_range(9, 16);
      // keep root indices ending in 111 mostly for long codes
      if (len >= 3 && len <= LEVEL_BITS && val[2:0] == 3'b111 && $urandom_range(0, 9) != 0)
        val[2:0] = 3'($urandom_range(0, 6));
      if (len > LEVEL_BITS && $urandom_range(0, 9) != 0)
        val[7:0] = {5'($urandom_range(0, 19)), 3'b111};
      k = $urandom_range(0, 99);
      if (k < 4) len = 0;
      else if (k < 8) len = $urandom_range(MAX_CODE_BITS + 1, 31);
      else if (k < 12) sym = -1;
      else if (k < 15) sym = -int'($urandom_range(2, 1024));
      if (len >= 1 && len <= MAX_CODE_BITS && sym != -1) begin
        cw.val = val;
        cw.len = len;
        known_codes.push_back(cw);
        if (known_codes.size() > CODE_MEMORY) void'(known_codes.pop_front());
      end
      put_code(val, LEN_W'(len), sym[SYM_W:0]);
    end else if (pick < 88 && known_codes.size() > 0) begin
      cw = known_codes[$urandom_range(0, known_codes.size() - 1)];
      wide = ($urandom << cw.len) | (32'(cw.val) & ((32'd1 << cw.len) - 1));
      query(wide[CODE_W-1:0]);
    end else begin
      query(CODE_W'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, skipped and rejected inserts, overlaps, both levels
    query(16'h0000);
    put_code(16'h0005, 5'd0, 11'sd5);
    put_code(16'h0003, 5'd3, -11'sd1);
    put_code(16'hffff, 5'd17, 11'sd9);
    put_code(16'h0000, 5'd31, 11'sd1023);
    put_code(16'hfffe, 5'd1, 11'sd1023);
    put_code(16'h00ff, 5'd8, -11'sd2);
    put_code(16'h0001, 5'd9, 11'sd341);
    put_code(16'hffff, 5'd16, 11'sd682);
    put_code(16'h8003, 5'd16, 11'sd7);
    query(16'h0000);
    query(16'hffff);
    query(16'h0201);
    query(16'h0101);
    query(16'h8003);
    query(16'h8103);
    query(16'h0005);
    put_code(16'h0000, 5'd8, 11'sd3);
    query(16'hff00);
    query(16'hfffe);
    put_code(16'h0007, 5'd3, 11'sd0);
    query(16'h12ff);

    // random traffic under each idling mix
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_pct_tab[p];
      stall_pct = stall_pct_tab[p];
      repeat (RANDOM_ITEMS / 4) random_transaction();
    end
    in_valid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
